/* design/sba_pkg.sv */
// Shared types and constants for the spectrum bar autoscaler.
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS) > 0 ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
    localparam int MAG_W       = 16;
    localparam int BAR_W       = 6;
    localparam int NUM_W       = MAG_W + BAR_W;
    localparam int BAR_FULL    = 47;
    localparam int ROW_BOTTOM  = 63;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             frame_end;
    } t_bin_in;

    typedef struct packed {
        logic [5:0] column;
        logic [5:0] bar_height;
        logic [5:0] top_row;
        logic       draw_bar;
        logic       last_column;
    } t_bar_out;

endpackage

`default_nettype wire

/* design/spectrum_bar_autoscaler.sv */
// Top level of the spectrum bar autoscaler.
// Bins are taken one per cycle into a 64-entry magnitude memory while the
// running peak (starting at 1) is tracked; bins past the column capacity are
// dropped. After the beat that carries frame_end, the input stalls and one
// bar beat per stored column comes out in column order. Each bar goes through
// a memory read, a multiply by the full height, a bit-serial divide by the
// peak plus a hand-over of its result, then the output register load. The
// input stays stalled until the last column's bar is loaded, including every
// cycle the receiver stalls a waiting bar.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bar_autoscaler
    import sba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_bin_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output t_bar_out      o_data,
    input  wire logic     i_stall
);

    localparam logic [2:0] S_FILL  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [MAG_W-1:0] r_mem [MAX_COLUMNS];
    logic [MAG_W-1:0] r_rd_data;

    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [MAG_W-1:0] r_peak;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_last_col;
    logic             r_oval;
    t_bar_out         r_out;

    logic             w_in_acc;
    logic             w_room;
    logic [CNT_W-1:0] w_count_new;
    logic             w_out_free;
    logic             w_done;
    logic [BAR_W-1:0] w_height;

    assign w_in_acc    = i_valid && (r_state == S_FILL);
    assign w_room      = r_count < CNT_W'(MAX_COLUMNS);
    assign w_count_new = r_count + CNT_W'(w_room);
    assign w_out_free  = !r_oval || !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_room) begin
            r_mem[r_count[COL_W-1:0]] <= i_data.magnitude;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_col];
        end
    end

    sba_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_START),
        .i_mag    (r_rd_data),
        .i_peak   (r_peak),
        .o_done   (w_done),
        .o_height (w_height)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_count <= '0;
            r_peak  <= MAG_W'(1);
            r_col   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_FILL: begin
                    if (w_in_acc) begin
                        r_count <= w_count_new;
                        if (w_room && i_data.magnitude > r_peak) begin
                            r_peak <= i_data.magnitude;
                        end
                        if (i_data.frame_end) begin
                            r_col   <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ:  r_state <= S_START;
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (r_col == r_last_col) begin
                            r_count <= '0;
                            r_peak  <= MAG_W'(1);
                            r_state <= S_FILL;
                        end else begin
                            r_col   <= r_col + COL_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_data.frame_end) begin
            r_last_col <= COL_W'(w_count_new - CNT_W'(1));
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out.column      <= 6'(r_col);
            r_out.bar_height  <= w_height;
            r_out.top_row     <= 6'(ROW_BOTTOM) - w_height;
            r_out.draw_bar    <= |w_height;
            r_out.last_column <= r_col == r_last_col;
        end
    end

    assign o_stall = r_state != S_FILL;
    assign o_valid = r_oval;
    assign o_data  = r_out;

endmodule

`default_nettype wire

/* design/sba_scale.sv */
// Bar height scaler: magnitude times full height, divided by the peak one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module sba_scale
    import sba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MAG_W-1:0] i_mag,
    input  wire logic [MAG_W-1:0] i_peak,
    output logic                  o_done,
    output logic [BAR_W-1:0]      o_height
);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_div;
    logic [BAR_W-1:0] r_q;
    logic             r_nz;
    logic             r_busy;
    logic [2:0]       r_step;
    logic             r_done;
    logic             w_ge;
    logic [BAR_W-1:0] w_h;

    assign w_ge = r_rem >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'(BAR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {{BAR_W{1'b0}}, i_mag} * NUM_W'(BAR_FULL);
            r_div <= {{BAR_W{1'b0}}, i_peak} << (BAR_W - 1);
            r_q   <= '0;
            r_nz  <= |i_mag;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_q   <= {r_q[BAR_W-2:0], w_ge};
        end
    end

    always_comb begin
        w_h = r_q;
        if (w_h > BAR_W'(BAR_FULL)) begin
            w_h = BAR_W'(BAR_FULL);
        end
        if (w_h == '0 && r_nz) begin
            w_h = BAR_W'(1);
        end
    end

    assign o_done   = r_done;
    assign o_height = w_h;

endmodule

`default_nettype wire
